### rtl/core/pqls_pkg.sv
package pqls_pkg;

    // One stored entry of the queue.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] pri;
    } entry_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Input operation codes.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int COUNT_OUT_W = 7;

endpackage

### rtl/core/pqls_cmp.sv
module pqls_cmp
    import pqls_pkg::*;
(
    input  entry_t cand,
    input  entry_t best,
    output logic   cand_wins
);

    // Higher priority wins, then larger value. A full tie keeps the incumbent.
    always_comb
    begin
        cand_wins = (cand.pri > best.pri) ||
                    ((cand.pri == best.pri) && (cand.value > best.value));
    end

endmodule

### rtl/core/priority_queue_linear_scan.sv
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid, in_ready   | mode, item_value, item_priority
// output  | out       | out_valid, out_ready | status, removed_value, removed_priority,
//         |           |                      | top_valid, top_value, top_priority, entry_count
//
// An insert writes the entry and updates the tracked top as it is accepted, then
// posts the result. A remove is accepted, then scans the N entries held before it
// through the single registered read port of the entry memory, which is walked one
// entry per cycle, and then posts the result.
// Reset clears the count and the tracked top; the entry memory needs no clearing pass.
// Only one item is in work at a time; a result waiting in the output register holds
// the sequencer until it is taken.
module priority_queue_linear_scan
    import pqls_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic signed [31:0]  item_value,
    input  logic signed [15:0]  item_priority,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic signed [31:0]  removed_value,
    output logic signed [15:0]  removed_priority,
    output logic                top_valid,
    output logic signed [31:0]  top_value,
    output logic signed [15:0]  top_priority,
    output logic [6:0]          entry_count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // Entry memory: one write port, one registered read port.
    entry_t          mem [DEPTH];
    entry_t          rd_data_reg;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    entry_t          wr_data;
    logic [IW-1:0]   rd_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer and datapath registers.
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    entry_t         top_reg, top_next;
    logic [IW-1:0]  top_idx_reg, top_idx_next;
    logic           top_ok_reg, top_ok_next;
    status_t        stat_reg, stat_next;
    entry_t         removed_reg, removed_next;
    logic [IW-1:0]  skip_reg, skip_next;
    logic [CW-1:0]  scan_n_reg, scan_n_next;
    logic [CW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic           pend_reg, pend_next;
    logic [IW-1:0]  pend_idx_reg, pend_idx_next;

    logic           out_valid_reg, out_valid_next;
    status_t        out_stat_reg, out_stat_next;
    entry_t         out_removed_reg, out_removed_next;
    logic           out_top_ok_reg, out_top_ok_next;
    entry_t         out_top_reg, out_top_next;
    logic [CW-1:0]  out_count_reg, out_count_next;

    // The shared compare unit: an incoming entry on insert, a scanned entry on remove.
    entry_t  cmp_cand;
    entry_t  in_entry;
    logic    cand_wins;

    assign in_entry.value = item_value;
    assign in_entry.pri   = item_priority;

    pqls_cmp u_cmp (
        .cand      (cmp_cand),
        .best      (top_reg),
        .cand_wins (cand_wins)
    );

    assign in_ready = (state_reg == ST_IDLE);

    logic in_accept;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        top_next         = top_reg;
        top_idx_next     = top_idx_reg;
        top_ok_next      = top_ok_reg;
        stat_next        = stat_reg;
        removed_next     = removed_reg;
        skip_next        = skip_reg;
        scan_n_next      = scan_n_reg;
        rd_ptr_next      = rd_ptr_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        out_valid_next   = out_valid_reg;
        out_stat_next    = out_stat_reg;
        out_removed_next = out_removed_reg;
        out_top_ok_next  = out_top_ok_reg;
        out_top_next     = out_top_reg;
        out_count_next   = out_count_reg;
        wr_en            = 1'b0;
        wr_addr          = count_reg[IW-1:0];
        wr_data          = in_entry;
        rd_addr          = rd_ptr_reg[IW-1:0];
        cmp_cand         = in_entry;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    removed_next = '0;
                    stat_next    = STAT_OK;
                    state_next   = ST_DONE;
                    if (op_t'(mode) == OP_INSERT)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            // Append; the new entry is the top if none is tracked or if it strictly wins,
                            // since an earlier entry wins a full tie.
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (!top_ok_reg || cand_wins)
                            begin
                                top_next     = in_entry;
                                top_idx_next = count_reg[IW-1:0];
                                top_ok_next  = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = STAT_EMPTY;
                        end
                        else
                        begin
                            // The tracked top is the one removed. One pass then closes
                            // the gap and finds the new top together.
                            removed_next = top_reg;
                            skip_next    = top_idx_reg;
                            scan_n_next  = count_reg;
                            count_next   = count_reg - 1'b1;
                            rd_ptr_next  = '0;
                            pend_next    = 1'b0;
                            top_ok_next  = 1'b0;
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next read.
                if (rd_ptr_reg < scan_n_reg)
                begin
                    rd_ptr_next   = rd_ptr_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_ptr_reg[IW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Consume the entry read last cycle, skipping the removed one.
                cmp_cand = rd_data_reg;
                if (pend_reg && (pend_idx_reg != skip_reg))
                begin
                    if (pend_idx_reg > skip_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pend_idx_reg - 1'b1;
                        wr_data = rd_data_reg;
                    end
                    if (!top_ok_reg || cand_wins)
                    begin
                        top_next     = rd_data_reg;
                        top_idx_next = (pend_idx_reg > skip_reg) ?
                                       (pend_idx_reg - 1'b1) : pend_idx_reg;
                        top_ok_next  = 1'b1;
                    end
                end

                if (!pend_reg && (rd_ptr_reg >= scan_n_reg))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_stat_next    = stat_reg;
                    out_removed_next = removed_reg;
                    out_top_ok_next  = top_ok_reg;
                    out_top_next     = top_ok_reg ? top_reg : '0;
                    out_count_next   = count_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            top_ok_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            top_ok_reg    <= top_ok_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg         <= top_next;
        top_idx_reg     <= top_idx_next;
        stat_reg        <= stat_next;
        removed_reg     <= removed_next;
        skip_reg        <= skip_next;
        scan_n_reg      <= scan_n_next;
        rd_ptr_reg      <= rd_ptr_next;
        pend_idx_reg    <= pend_idx_next;
        out_stat_reg    <= out_stat_next;
        out_removed_reg <= out_removed_next;
        out_top_ok_reg  <= out_top_ok_next;
        out_top_reg     <= out_top_next;
        out_count_reg   <= out_count_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_stat_reg;
    assign removed_value    = out_removed_reg.value;
    assign removed_priority = out_removed_reg.pri;
    assign top_valid        = out_top_ok_reg;
    assign top_value        = out_top_reg.value;
    assign top_priority     = out_top_reg.pri;
    assign entry_count      = COUNT_OUT_W'(out_count_reg);

endmodule

### sim/pqls_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the priority queue, keeps its own copy of the
// held entries and checks every result against the predicted step.
module pqls_checker
    import pqls_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                mode,
    input  logic signed [31:0]  item_value,
    input  logic signed [15:0]  item_priority,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          status,
    input  logic signed [31:0]  removed_value,
    input  logic signed [15:0]  removed_priority,
    input  logic                top_valid,
    input  logic signed [31:0]  top_value,
    input  logic signed [15:0]  top_priority,
    input  logic [6:0]          entry_count,
    output int                  mismatch_count,
    output int                  outstanding,
    output int                  checked_count
);

    typedef struct {
        status_t            st;
        logic signed [31:0] rem_val;
        logic signed [15:0] rem_pri;
        logic               top_ok;
        logic signed [31:0] top_val;
        logic signed [15:0] top_pri;
        logic [6:0]         count;
    } step_result_t;

    // Entries in insertion order, as the block should hold them.
    logic signed [31:0] held_val[$];
    logic signed [15:0] held_pri[$];
    step_result_t       expected_q[$];
    int                 errors;
    int                 checked;

    // Highest priority wins, then larger value; a strict compare keeps the
    // earliest entry on a full tie.
    function automatic int top_index();
        int best;
        best = 0;
        for (int i = 1; i < held_val.size(); i++) begin
            if (held_pri[i] > held_pri[best] ||
                (held_pri[i] == held_pri[best] && held_val[i] > held_val[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic step_result_t predict_step(op_t op, logic signed [31:0] v,
                                                  logic signed [15:0] p);
        step_result_t r;
        int t;
        r.st = STAT_OK;
        r.rem_val = '0;
        r.rem_pri = '0;
        r.top_ok = 1'b0;
        r.top_val = '0;
        r.top_pri = '0;
        if (op == OP_INSERT) begin
            if (held_val.size() >= DEPTH)
                r.st = STAT_FULL;
            else
            begin
                held_val.push_back(v);
                held_pri.push_back(p);
            end
        end
        else if (held_val.size() == 0)
            r.st = STAT_EMPTY;
        else
        begin
            t = top_index();
            r.rem_val = held_val[t];
            r.rem_pri = held_pri[t];
            held_val.delete(t);
            held_pri.delete(t);
        end
        if (held_val.size() > 0) begin
            t = top_index();
            r.top_ok = 1'b1;
            r.top_val = held_val[t];
            r.top_pri = held_pri[t];
        end
        r.count = 7'(held_val.size());
        return r;
    endfunction

    function automatic bit same_result(step_result_t a, step_result_t b);
        return a.st === b.st && a.rem_val === b.rem_val && a.rem_pri === b.rem_pri &&
               a.top_ok === b.top_ok && a.top_val === b.top_val &&
               a.top_pri === b.top_pri && a.count === b.count;
    endfunction

    always @(posedge clk) begin
        step_result_t got;
        step_result_t want;
        if (!rst_n) begin
            held_val.delete();
            held_pri.delete();
            expected_q.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.push_back(predict_step(op_t'(mode), item_value, item_priority));
            if (out_valid && out_ready) begin
                got.st = status_t'(status);
                got.rem_val = removed_value;
                got.rem_pri = removed_priority;
                got.top_ok = top_valid;
                got.top_val = top_value;
                got.top_pri = top_priority;
                got.count = entry_count;
                checked++;
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("pqls_checker: result %0d arrived with none expected",
                                 checked);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (!same_result(got, want)) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("pqls_checker: result %0d expected st=%0d rem=%0d/%0d top=%0b %0d/%0d n=%0d",
                                     checked, want.st, want.rem_val, want.rem_pri,
                                     want.top_ok, want.top_val, want.top_pri, want.count);
                            $display("pqls_checker: result %0d actual   st=%0d rem=%0d/%0d top=%0b %0d/%0d n=%0d",
                                     checked, got.st, got.rem_val, got.rem_pri,
                                     got.top_ok, got.top_val, got.top_pri, got.count);
                        end
                    end
                end
            end
        end
        mismatch_count <= errors;
        outstanding <= expected_q.size();
        checked_count <= checked;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the priority queue. The checker beside the block
// does all prediction and comparison; this module only drives items, sets
// the idling of both channels and decides the outcome at the end.
module tb_top;
    import pqls_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASES = 4;
    // A remove walks every held entry, so one item can keep the block busy
    // for a whole scan; the final settle covers that with margin.
    localparam int SETTLE_CYCLES = DEPTH + 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               mode = OP_INSERT;
    logic signed [31:0] item_value = '0;
    logic signed [15:0] item_priority = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic signed [15:0] removed_priority;
    logic               top_valid;
    logic signed [31:0] top_value;
    logic signed [15:0] top_priority;
    logic [6:0]         entry_count;

    int mismatch_count;
    int outstanding;
    int checked_count;

    // Chance, in percent, that the sender idles or the receiver stalls in a cycle.
    int idle_pct = 0;
    int stall_pct = 0;
    int insert_count = 0;
    int remove_count = 0;

    always #5 clk = ~clk;

    priority_queue_linear_scan #(.DEPTH(DEPTH)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .item_value       (item_value),
        .item_priority    (item_priority),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .removed_value    (removed_value),
        .removed_priority (removed_priority),
        .top_valid        (top_valid),
        .top_value        (top_value),
        .top_priority     (top_priority),
        .entry_count      (entry_count)
    );

    pqls_checker #(.DEPTH(DEPTH)) step_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .item_value       (item_value),
        .item_priority    (item_priority),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .removed_value    (removed_value),
        .removed_priority (removed_priority),
        .top_valid        (top_valid),
        .top_value        (top_value),
        .top_priority     (top_priority),
        .entry_count      (entry_count),
        .mismatch_count   (mismatch_count),
        .outstanding      (outstanding),
        .checked_count    (checked_count)
    );

    // The receiver draws a fresh ready every cycle from the current stall rate.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one item and returns once it has been accepted. Valid is left
    // high afterwards so that back-to-back items never lower and raise it in
    // the same time step; it drops only when the sender decides to idle.
    task automatic send_item(op_t op, logic signed [31:0] v, logic signed [15:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= op;
        item_value <= v;
        item_priority <= p;
        if (op == OP_INSERT)
            insert_count++;
        else
            remove_count++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Holds the sender off until every expected result has been taken. The
    // checker's count is registered, so the clock steps before it is read.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Values and priorities often come from a narrow band so that priority and value ties are
    // frequent, with full-range draws and the extremes mixed in.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(4))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $signed($urandom_range(6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_priority();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return 16'($signed($urandom_range(4)) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int left;
        int episode_len;
        int insert_bias;
        op_t op;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A remove from the empty store must be refused and
        // report zeros for both the removed and the top entry.
        send_item(OP_REMOVE, 32'sh1234_5678, 16'sh0101);
        // Two entries at the lowest priority: both stay selectable, and on
        // the priority tie the larger value goes first.
        send_item(OP_INSERT, 32'sh8000_0000, 16'sh8000);
        send_item(OP_INSERT, 32'sh7FFF_FFFF, 16'sh8000);
        send_item(OP_REMOVE, '0, '0);
        send_item(OP_REMOVE, '1, '1);
        // Store is empty again; a second refused remove checks nothing moved.
        send_item(OP_REMOVE, '0, '0);
        // Highest priority beats any value; a full tie keeps insertion order.
        send_item(OP_INSERT, 32'sd5, 16'sd7);
        send_item(OP_INSERT, -32'sd1, 16'sh7FFF);
        send_item(OP_INSERT, 32'sd5, 16'sd7);
        send_item(OP_INSERT, 32'sd0, 16'sd0);
        send_item(OP_INSERT, 32'sh7FFF_FFFF, 16'sd7);
        send_item(OP_INSERT, 32'sh8000_0000, 16'sh7FFF);
        repeat (7)
            send_item(OP_REMOVE, $urandom, 16'($urandom));
        wait_drained();

        // Random part in four idling phases: none, sender idle, receiver
        // stalled, and both lightly. Episodes lean toward inserts or removes
        // so that the store reaches full and empty many times, where the
        // refusal cases live.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 86;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 86;
                end
                default:
                begin
                    idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
            left = RANDOM_ITEMS / PHASES;
            while (left > 0)
            begin
                episode_len = $urandom_range(150, 20);
                case ($urandom_range(2))
                    0:       insert_bias = 90;
                    1:       insert_bias = 50;
                    default: insert_bias = 15;
                endcase
                for (int k = 0; k < episode_len && left > 0; k++)
                begin
                    if ($urandom_range(99) < insert_bias)
                        op = OP_INSERT;
                    else
                        op = OP_REMOVE;
                    send_item(op, pick_value(), pick_priority());
                    left--;
                end
            end
            // The sender pauses here until every expected result has come.
            wait_drained();
        end

        idle_pct = 0;
        stall_pct = 0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb_top: %0d items sent (%0d inserts, %0d removes), %0d results checked",
                 insert_count + remove_count, insert_count, remove_count, checked_count);
        $display("tb_top: directed ties and extremes, then four idling phases of random items");
        if (mismatch_count == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // A generous cap well beyond the slowest correct run.
    initial
    begin
        #10000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pqls_pkg.sv
rtl/core/pqls_cmp.sv
rtl/core/priority_queue_linear_scan.sv
sim/pqls_checker.sv
sim/tb_top.sv
